[hw/rtl/owvc_pkg.sv]
`timescale 1ns / 1ps
package owvc_pkg;

  // angle resolution of the heading input
  localparam int ANGLE_STEPS = 1024;
  localparam int ANGLE_W     = $clog2(ANGLE_STEPS);
  localparam int QTR_STEPS   = ANGLE_STEPS / 4;
  localparam int QTR_W       = $clog2(QTR_STEPS);

  // angle of one table step in radians
  localparam real QTR_RAD = 3.14159265358979323846 / (2.0 * QTR_STEPS);

  // kinematic coefficients, value*1024
  localparam logic signed [16:0] COEF_P = 17'sd18618;
  localparam logic signed [16:0] COEF_Q = 17'sd32247;
  localparam logic signed [16:0] COEF_R = 17'sd3351;

  localparam logic signed [42:0] WHEEL_MAX = 43'sd8388607;
  localparam logic signed [42:0] WHEEL_MIN = -43'sd8388608;

  // quarter wave sine table, 0 .. pi/2 inclusive
  typedef logic [14:0] sin_lut_t [0:QTR_STEPS];

  function automatic sin_lut_t build_sin_lut();
    sin_lut_t lut;
    real      v;
    for (int i = 0; i <= QTR_STEPS; i++) begin
      v = 32767.0 * $sin(QTR_RAD * i);
      lut[i] = 15'($rtoi(v + 0.5));
    end
    return lut;
  endfunction

  localparam sin_lut_t SIN_LUT = build_sin_lut();

  // full circle sine from the quarter table
  function automatic logic signed [15:0] sin_of(logic [ANGLE_W-1:0] k);
    logic [1:0]       quad;
    logic [QTR_W:0]   m;
    logic [QTR_W:0]   idx;
    logic signed [15:0] mag;
    quad = k[ANGLE_W-1 -: 2];
    m    = {1'b0, k[QTR_W-1:0]};
    idx  = quad[0] ? ((QTR_W+1)'(QTR_STEPS) - m) : m;
    mag  = signed'({1'b0, SIN_LUT[idx]});
    return quad[1] ? -mag : mag;
  endfunction

  // error terms handed from the sensing half to the drive half
  typedef struct packed {
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [21:0] pw;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
  } sense_t;

endpackage

[hw/rtl/owvc_sense.sv]
`timescale 1ns / 1ps
module owvc_sense (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [15:0]          ref_x_i,
  input  logic signed [15:0]          ref_y_i,
  input  logic signed [15:0]          ref_w_i,
  input  logic signed [15:0]          enc_a_i,
  input  logic signed [15:0]          enc_b_i,
  input  logic signed [15:0]          enc_c_i,
  input  logic signed [15:0]          enc_d_i,
  input  logic [owvc_pkg::ANGLE_W-1:0] yaw_i,
  input  logic signed [15:0]          obs_x_i,
  input  logic signed [15:0]          obs_y_i,
  input  logic signed [15:0]          obs_w_i,
  output logic                        valid_o,
  output owvc_pkg::sense_t            sense_o
);
  import owvc_pkg::*;

  logic [2:0] v_q;

  // stage 1: sine/cosine lookup and wheel sums
  logic signed [15:0] sn1_q, cs1_q, rx1_q, ry1_q, rw1_q, ox1_q, oy1_q, ow1_q;
  logic signed [17:0] sa1_q, sb1_q, sc1_q;
  logic signed [17:0] ea, eb, ec, ed;
  logic [ANGLE_W-1:0] yaw_c;

  assign ea = 18'(enc_a_i);
  assign eb = 18'(enc_b_i);
  assign ec = 18'(enc_c_i);
  assign ed = 18'(enc_d_i);
  assign yaw_c = yaw_i + ANGLE_W'(QTR_STEPS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn1_q <= sin_of(yaw_i);
      cs1_q <= sin_of(yaw_c);
      rx1_q <= ref_x_i;
      ry1_q <= ref_y_i;
      rw1_q <= ref_w_i;
      ox1_q <= obs_x_i;
      oy1_q <= obs_y_i;
      ow1_q <= obs_w_i;
      sa1_q <= ea + eb + ec + ed;
      sb1_q <= ea - eb + ec - ed;
      sc1_q <= ea + eb - ec - ed;
    end
  end

  // stage 2: rotation and measurement products
  logic signed [31:0] cx2_q, sy2_q, sx2_q, cy2_q;
  logic signed [35:0] mx2_q, my2_q, mw2_q;
  logic signed [15:0] rw2_q, ox2_q, oy2_q, ow2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx2_q <= cs1_q * rx1_q;
      sy2_q <= sn1_q * ry1_q;
      sx2_q <= sn1_q * rx1_q;
      cy2_q <= cs1_q * ry1_q;
      mx2_q <= 36'(COEF_P) * 36'(sa1_q);
      my2_q <= 36'(COEF_Q) * 36'(sb1_q);
      mw2_q <= 36'(COEF_R) * 36'(sc1_q);
      rw2_q <= rw1_q;
      ox2_q <= ox1_q;
      oy2_q <= oy1_q;
      ow2_q <= ow1_q;
    end
  end

  // stage 3: scale back and form the errors
  logic signed [32:0] lx_s, ly_s;
  logic signed [24:0] lx, ly, vx, vy;
  logic signed [21:0] vw;
  sense_t s3_q;

  assign lx_s = 33'(cx2_q) - 33'(sy2_q);
  assign ly_s = 33'(sx2_q) + 33'(cy2_q);
  assign lx   = 25'(lx_s >>> 15);
  assign ly   = 25'(ly_s >>> 15);
  assign vx   = 25'(mx2_q >>> 10);
  assign vy   = 25'(my2_q >>> 10);
  assign vw   = 22'(mw2_q >>> 10);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q.dx <= lx - vx;
      s3_q.dy <= ly - vy;
      s3_q.pw <= 22'(rw2_q) - vw - 22'(ow2_q);
      s3_q.ox <= ox2_q;
      s3_q.oy <= oy2_q;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  assign valid_o = v_q[2];
  assign sense_o = s3_q;

endmodule

[hw/rtl/owvc_drive.sv]
`timescale 1ns / 1ps
module owvc_drive (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  owvc_pkg::sense_t   sense_i,
  input  logic [15:0]        kp_i,
  output logic               valid_o,
  output logic signed [23:0] wheel_a_o,
  output logic signed [23:0] wheel_b_o,
  output logic signed [23:0] wheel_c_o,
  output logic signed [23:0] wheel_d_o,
  output logic               clipped_o
);
  import owvc_pkg::*;

  logic [3:0] v_q;

  // stage 4: gain on x and y error
  logic signed [41:0] gx4_q, gy4_q;
  logic signed [21:0] pw4_q;
  logic signed [15:0] ox4_q, oy4_q;
  logic signed [41:0] kp_s;

  assign kp_s = signed'({26'd0, kp_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gx4_q <= kp_s * 42'(sense_i.dx);
      gy4_q <= kp_s * 42'(sense_i.dy);
      pw4_q <= sense_i.pw;
      ox4_q <= sense_i.ox;
      oy4_q <= sense_i.oy;
    end
  end

  // stage 5: observer correction
  logic signed [34:0] px5_q, py5_q;
  logic signed [21:0] pw5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px5_q <= 35'(gx4_q >>> 8) - 35'(ox4_q);
      py5_q <= 35'(gy4_q >>> 8) - 35'(oy4_q);
      pw5_q <= pw4_q;
    end
  end

  // stage 6: inverse kinematics products
  logic signed [50:0] tp6_q, tq6_q, tr6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tp6_q <= 51'(COEF_P) * 51'(px5_q);
      tq6_q <= 51'(COEF_Q) * 51'(py5_q);
      tr6_q <= 51'(COEF_R) * 51'(pw5_q);
    end
  end

  // stage 7: wheel sums and saturation
  logic signed [52:0] sum_a, sum_b, sum_c, sum_d;
  logic signed [42:0] raw [4];
  logic signed [23:0] sat [4];
  logic [3:0]         clip;

  assign sum_a = 53'(tp6_q) + 53'(tq6_q) + 53'(tr6_q);
  assign sum_b = 53'(tp6_q) - 53'(tq6_q) + 53'(tr6_q);
  assign sum_c = 53'(tp6_q) + 53'(tq6_q) - 53'(tr6_q);
  assign sum_d = 53'(tp6_q) - 53'(tq6_q) - 53'(tr6_q);
  assign raw[0] = 43'(sum_a >>> 10);
  assign raw[1] = 43'(sum_b >>> 10);
  assign raw[2] = 43'(sum_c >>> 10);
  assign raw[3] = 43'(sum_d >>> 10);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (raw[i] > WHEEL_MAX) begin
        sat[i]  = 24'(WHEEL_MAX);
        clip[i] = 1'b1;
      end else if (raw[i] < WHEEL_MIN) begin
        sat[i]  = 24'(WHEEL_MIN);
        clip[i] = 1'b1;
      end else begin
        sat[i]  = 24'(raw[i]);
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wheel_a_o <= sat[0];
      wheel_b_o <= sat[1];
      wheel_c_o <= sat[2];
      wheel_d_o <= sat[3];
      clipped_o <= |clip;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  assign valid_o = v_q[3];

endmodule

[hw/rtl/omni_wheel_velocity_controller_top.sv]
// channel   | direction | signals
// ----------+-----------+----------------------------------------------
// s_axis    | in        | tvalid, tready, tdata (176 bit)
// m_axis    | out       | tvalid, tready, tdata (96 bit), tuser (1 bit)
// kp        | in        | kp_we_i, kp_wdata_i (16 bit, unsigned Q8.8)
//
// one request per cycle while the output is not held; each result passes through
// the seven register stages (lookup, products, errors, gain, observer,
// wheel products, wheel sums with saturation).
// reset clears the valid bits and loads kp with 3.0; no clearing pass.
// all stages move together; a held output freezes the pipeline and drops
// s_axis_tready, so nothing is lost or repeated.
`timescale 1ns / 1ps
module omni_wheel_velocity_controller_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ref_x, ref_y, ref_w, enc_a, enc_b, enc_c, enc_d, yaw(10), obs_x, obs_y, obs_w, pad
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // wheel_a, wheel_b, wheel_c, wheel_d
  output logic [95:0]  m_axis_tdata,
  // clipped
  output logic         m_axis_tuser,
  input  logic         kp_we_i,
  input  logic [15:0]  kp_wdata_i
);
  import owvc_pkg::*;

  logic [15:0] kp_q;
  logic        en;
  logic        sense_valid;
  sense_t      sense;
  logic signed [23:0] wa, wb, wc, wd;

  // gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= 16'd768;
    end else if (kp_we_i) begin
      kp_q <= kp_wdata_i;
    end
  end

  // pipeline advances unless the output is held
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  owvc_sense u_sense (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .ref_x_i (s_axis_tdata[15:0]),
    .ref_y_i (s_axis_tdata[31:16]),
    .ref_w_i (s_axis_tdata[47:32]),
    .enc_a_i (s_axis_tdata[63:48]),
    .enc_b_i (s_axis_tdata[79:64]),
    .enc_c_i (s_axis_tdata[95:80]),
    .enc_d_i (s_axis_tdata[111:96]),
    .yaw_i   (s_axis_tdata[121:112]),
    .obs_x_i (s_axis_tdata[137:122]),
    .obs_y_i (s_axis_tdata[153:138]),
    .obs_w_i (s_axis_tdata[169:154]),
    .valid_o (sense_valid),
    .sense_o (sense)
  );

  owvc_drive u_drive (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (sense_valid),
    .sense_i   (sense),
    .kp_i      (kp_q),
    .valid_o   (m_axis_tvalid),
    .wheel_a_o (wa),
    .wheel_b_o (wb),
    .wheel_c_o (wc),
    .wheel_d_o (wd),
    .clipped_o (m_axis_tuser)
  );

  assign m_axis_tdata = {wd, wc, wb, wa};

endmodule

[tb/sv/omni_wheel_velocity_controller_top_test.sv]
`timescale 1ns / 1ps
module omni_wheel_velocity_controller_top_test;
  import owvc_pkg::*;

  typedef struct {
    logic signed [15:0] ref_x, ref_y, ref_w;
    logic signed [15:0] enc_a, enc_b, enc_c, enc_d;
    logic [9:0]         yaw;
    logic signed [15:0] obs_x, obs_y, obs_w;
  } sample_t;

  typedef struct {
    logic signed [23:0] wa, wb, wc, wd;
    logic               clip;
  } command_t;

  localparam int LIMIT_CYCLES = 400000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         kp_we_i;
  logic [15:0]  kp_wdata_i;

  command_t expected_cmds[$];
  logic [15:0] gain_q88;
  int mismatches;
  int cycle_count;
  bit hold_rx;
  bit random_rx_gaps;
  longint sin_tab[0:1023];

  omni_wheel_velocity_controller_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .kp_we_i       (kp_we_i),
    .kp_wdata_i    (kp_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[omni_wheel_velocity_controller_top] ERROR");
      $finish;
    end
  end

  // sine table, rounded half away from zero
  function automatic longint round_sin(int k);
    real v;
    v = 32767.0 * $sin(2.0 * 3.14159265358979323846 * k / 1024.0);
    return (v >= 0.0) ? longint'($floor(v + 0.5)) : -longint'($floor(-v + 0.5));
  endfunction

  function automatic longint asr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp_wheel(longint v, ref logic clip);
    if (v > 8388607) begin
      clip = 1'b1;
      return 8388607;
    end
    if (v < -8388608) begin
      clip = 1'b1;
      return -8388608;
    end
    return v;
  endfunction

  // wheel commands for one sample
  function automatic command_t wheel_commands(sample_t s, logic [15:0] kp);
    longint sn, cs, lx, ly, vx, vy, vw, px, py, pw, p, q, r;
    command_t c;
    logic clip;
    p = 18618; q = 32247; r = 3351;
    clip = 1'b0;
    sn = sin_tab[s.yaw];
    cs = sin_tab[(s.yaw + 256) % 1024];
    lx = asr_floor(cs * s.ref_x - sn * s.ref_y, 15);
    ly = asr_floor(sn * s.ref_x + cs * s.ref_y, 15);
    vx = asr_floor(p * (longint'(s.enc_a) + s.enc_b + s.enc_c + s.enc_d), 10);
    vy = asr_floor(q * (longint'(s.enc_a) - s.enc_b + s.enc_c - s.enc_d), 10);
    vw = asr_floor(r * (longint'(s.enc_a) + s.enc_b - s.enc_c - s.enc_d), 10);
    px = asr_floor(longint'(kp) * (lx - vx), 8) - s.obs_x;
    py = asr_floor(longint'(kp) * (ly - vy), 8) - s.obs_y;
    pw = (longint'(s.ref_w) - vw) - s.obs_w;
    c.wa = 24'(clamp_wheel(asr_floor(p * px + q * py + r * pw, 10), clip));
    c.wb = 24'(clamp_wheel(asr_floor(p * px - q * py + r * pw, 10), clip));
    c.wc = 24'(clamp_wheel(asr_floor(p * px + q * py - r * pw, 10), clip));
    c.wd = 24'(clamp_wheel(asr_floor(p * px - q * py - r * pw, 10), clip));
    c.clip = clip;
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // receiver stalls
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
      end else if (m_axis_tready && m_axis_tvalid) begin
        gap = random_rx_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap - 1) @(posedge clk_i);
          @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    command_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("unexpected command", 0, 0);
      end else begin
        w = expected_cmds.pop_front();
        if ($signed(m_axis_tdata[23:0]) != w.wa)
          report_mismatch("wheel_a", $signed(m_axis_tdata[23:0]), w.wa);
        if ($signed(m_axis_tdata[47:24]) != w.wb)
          report_mismatch("wheel_b", $signed(m_axis_tdata[47:24]), w.wb);
        if ($signed(m_axis_tdata[71:48]) != w.wc)
          report_mismatch("wheel_c", $signed(m_axis_tdata[71:48]), w.wc);
        if ($signed(m_axis_tdata[95:72]) != w.wd)
          report_mismatch("wheel_d", $signed(m_axis_tdata[95:72]), w.wd);
        if (m_axis_tuser != w.clip)
          report_mismatch("clipped", m_axis_tuser, w.clip);
      end
    end
  end

  // one request, with a random gap before it when gaps is set
  task automatic send_sample(sample_t s, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, s.obs_w, s.obs_y, s.obs_x, s.yaw, s.enc_d, s.enc_c, s.enc_b,
                      s.enc_a, s.ref_w, s.ref_y, s.ref_x};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_cmds.push_back(wheel_commands(s, gain_q88));
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    end_burst();
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [15:0] v);
    kp_we_i    <= 1'b1;
    kp_wdata_i <= v;
    @(posedge clk_i);
    kp_we_i    <= 1'b0;
    gain_q88 = v;
  endtask

  function automatic sample_t random_sample(int span);
    sample_t s;
    logic [15:0] f[10];
    for (int i = 0; i < 10; i++) begin
      case (span)
        0: f[i] = $urandom();
        1: f[i] = 16'($signed($urandom_range(0, 1024)) - 512);
        default: f[i] = ($urandom_range(0, 1)) ? 16'h7fff - $urandom_range(0, 3)
                                              : 16'h8000 + $urandom_range(0, 3);
      endcase
    end
    s.ref_x = f[0]; s.ref_y = f[1]; s.ref_w = f[2];
    s.enc_a = f[3]; s.enc_b = f[4]; s.enc_c = f[5]; s.enc_d = f[6];
    s.obs_x = f[7]; s.obs_y = f[8]; s.obs_w = f[9];
    s.yaw   = $urandom_range(0, 1023);
    return s;
  endfunction

  // field extremes, eighth-turn headings, clamp in both directions
  task automatic test_directed();
    sample_t s;
    s = '{default: '0};
    send_sample(s, 0);
    s = '{default: 16'sh7fff};
    s.yaw = 10'd1023;
    send_sample(s, 0);
    s = '{default: -16'sh8000};
    s.yaw = 10'd0;
    send_sample(s, 0);
    for (int k = 0; k < 8; k++) begin
      s = '{default: '0};
      s.ref_x = 16'sd1000;
      s.ref_y = -16'sd500;
      s.yaw = 10'(k * 128);
      send_sample(s, 1);
    end
    // large errors push wheels past the 24 bit range
    s = '{default: '0};
    s.ref_x = 16'sh7fff; s.ref_y = 16'sh7fff;
    s.enc_a = -16'sh8000; s.enc_c = -16'sh8000;
    send_sample(s, 0);
    s.ref_x = -16'sh8000; s.ref_y = -16'sh8000;
    s.enc_a = 16'sh7fff; s.enc_c = 16'sh7fff;
    send_sample(s, 0);
    s = '{default: '0};
    s.obs_w = 16'sh7fff; s.obs_x = -16'sh8000; s.obs_y = 16'sh5555;
    s.enc_b = 16'shaaaa; s.enc_d = 16'sh5555; s.ref_w = 16'shaaaa;
    send_sample(s, 0);
    drain();
  endtask

  task automatic test_random(int count, bit gaps);
    int span;
    for (int i = 0; i < count; i++) begin
      span = $urandom_range(0, 9);
      send_sample(random_sample(span < 5 ? 0 : (span < 9 ? 1 : 2)), gaps);
    end
    drain();
  endtask

  // output held off long enough to back up the pipeline
  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_sample(random_sample(0), 0);
    join
    drain();
  endtask

  initial begin
    mismatches = 0;
    cycle_count = 0;
    hold_rx = 1'b0;
    random_rx_gaps = 1'b0;
    gain_q88 = 16'd768;
    for (int k = 0; k < 1024; k++) sin_tab[k] = round_sin(k);
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    kp_we_i = 1'b0;
    kp_wdata_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(150, 0);
    random_rx_gaps = 1'b1;
    test_random(150, 1);
    write_gain(16'd0);
    test_random(80, 1);
    write_gain(16'hffff);
    test_directed();
    test_random(100, 1);
    write_gain(16'd256);
    test_backpressure();
    test_random(100, 0);
    write_gain(16'($urandom()));
    test_random(120, 1);

    if (mismatches == 0) begin
      $display("[omni_wheel_velocity_controller_top] OK");
    end else begin
      $display("[omni_wheel_velocity_controller_top] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/owvc_pkg.sv
hw/rtl/owvc_sense.sv
hw/rtl/owvc_drive.sv
hw/rtl/omni_wheel_velocity_controller_top.sv
tb/sv/omni_wheel_velocity_controller_top_test.sv
